// ===== rtl/core/swt_pkg.sv =====
// Shared types and codes for the structure table walker.
// No dependencies; every other file but swt_ifs imports this package.
package swt_pkg;

   typedef enum logic [2:0] {
      PH_HEADER   = 3'd0,
      PH_SKIP     = 3'd1,
      PH_FIRST    = 3'd2,
      PH_LEADNULL = 3'd3,
      PH_STRINGS  = 3'd4
   } swt_phase_type;

   typedef enum logic [2:0] {
      ST_COMPLETE  = 3'd0,
      ST_TOO_LONG  = 3'd1,
      ST_TOO_SHORT = 3'd2,
      ST_TRUNCATED = 3'd3,
      ST_TABLE_END = 3'd4
   } swt_status_type;

   localparam logic [7:0]  NUL_BYTE        = 8'h00;
   localparam logic [7:0]  HEADER_BYTES    = 8'd4;
   localparam logic [15:0] TABLE_SIZE_INIT = 16'hFFFF;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } swt_item_type;

   typedef struct packed {
      logic [7:0]     struct_type;
      logic [15:0]    struct_handle;
      logic [7:0]     struct_length;
      logic [7:0]     string_count;
      swt_status_type status;
   } swt_result_type;

   typedef struct packed {
      logic take;
      logic load;
   } swt_flow_type;

endpackage

// ===== rtl/core/swt_ifs.sv =====
// Valid/ready channel interfaces for request, response and register write.
// Depends on nothing; payload widths are fixed by the table format.
interface swt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;
   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface swt_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  struct_type;
   logic [15:0] struct_handle;
   logic [7:0]  struct_length;
   logic [7:0]  string_count;
   logic [2:0]  status;
   modport source (output valid, output struct_type, output struct_handle,
                   output struct_length, output string_count, output status,
                   input ready);
   modport sink   (input valid, input struct_type, input struct_handle,
                   input struct_length, input string_count, input status,
                   output ready);
endinterface

interface swt_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/smbios_table_walker.sv =====
// Structure table walker: one table byte per transfer, one result per structure.
// The byte that ends a structure passes the input register; its result is then loaded into the result register.
// Throughput: one byte per cycle, unless a finished result waits for a stalled response channel.
// Reset clears all walker state and the pipeline; table_size returns to 65535.
// Depends on swt_pkg, swt_ifs, swt_in_stage, swt_core and swt_out_stage.
module smbios_table_walker (
   input  logic      clock,
   input  logic      reset,
   swt_req_if.sink   req_if,
   swt_rsp_if.source rsp_if,
   swt_csr_if.sink   csr_if
);
   import swt_pkg::*;

   logic [15:0]    table_size_ff, table_size_in;
   logic           item_valid;
   swt_item_type   item;
   swt_flow_type   flow;
   swt_result_type result;
   logic           out_free;

   assign csr_if.ready  = 1'b1;
   assign table_size_in = (csr_if.valid && csr_if.ready) ? csr_if.data : table_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         table_size_ff <= TABLE_SIZE_INIT;
      end else begin
         table_size_ff <= table_size_in;
      end
   end

   swt_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .take       (flow.take),
      .item_valid (item_valid),
      .item       (item)
   );

   swt_core u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .table_size (table_size_ff),
      .out_free   (out_free),
      .flow       (flow),
      .result     (result)
   );

   swt_out_stage u_out (
      .clock    (clock),
      .reset    (reset),
      .load     (flow.load),
      .result   (result),
      .out_free (out_free),
      .rsp_if   (rsp_if)
   );

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      !(flow.load && rsp_if.valid && !rsp_if.ready))
      else $error("result register overwritten while stalled");

   a_load_needs_take: assert property (@(posedge clock) disable iff (reset)
      flow.load |-> (flow.take && item_valid))
      else $error("result loaded without consuming a byte");

   a_refill_drains: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready && item_valid) |-> flow.take)
      else $error("input register refilled before its byte was consumed");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_if.valid)
      else $error("response valid right after reset");

endmodule

// ===== rtl/core/swt_in_stage.sv =====
// Input register for table bytes.
// Depends on swt_pkg and swt_req_if.
module swt_in_stage (
   input  logic                 clock,
   input  logic                 reset,
   swt_req_if.sink              req_if,
   input  logic                 take,
   output logic                 item_valid,
   output swt_pkg::swt_item_type item
);
   import swt_pkg::*;

   logic         vld_ff, vld_in;
   swt_item_type item_ff;
   logic         load;

   assign req_if.ready = !vld_ff || take;
   assign load         = req_if.valid && req_if.ready;
   assign vld_in       = load || (vld_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff.data_byte <= req_if.data_byte;
         item_ff.last_byte <= req_if.last_byte;
      end
   end

   assign item_valid = vld_ff;
   assign item       = item_ff;

endmodule

// ===== rtl/core/swt_core.sv =====
// Walker state and the per-byte update: header capture, skip, string count.
// Depends on swt_pkg.
module swt_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   item_valid,
   input  swt_pkg::swt_item_type  item,
   input  logic [15:0]            table_size,
   input  logic                   out_free,
   output swt_pkg::swt_flow_type  flow,
   output swt_pkg::swt_result_type result
);
   import swt_pkg::*;

   swt_phase_type phase_ff, phase_in;
   logic [1:0]    hidx_ff, hidx_in;
   logic [7:0]    type_ff, type_in;
   logic [7:0]    length_ff, length_in;
   logic [15:0]   handle_ff, handle_in;
   logic [7:0]    left_ff, left_in;
   logic [7:0]    strings_ff, strings_in;
   logic          in_str_ff, in_str_in;
   logic          stopped_ff, stopped_in;

   logic          res_vld;
   logic          busy;
   logic          adv;
   logic [7:0]    b;
   logic          last;

   assign b    = item.data_byte;
   assign last = item.last_byte;

   always_comb begin
      phase_in   = phase_ff;
      hidx_in    = hidx_ff;
      type_in    = type_ff;
      length_in  = length_ff;
      handle_in  = handle_ff;
      left_in    = left_ff;
      strings_in = strings_ff;
      in_str_in  = in_str_ff;
      stopped_in = stopped_ff;
      res_vld    = 1'b0;
      busy       = 1'b0;
      result.struct_type   = type_ff;
      result.struct_handle = handle_ff;
      result.struct_length = length_ff;
      result.string_count  = strings_ff;
      result.status        = ST_COMPLETE;

      if (stopped_ff) begin
         if (last) begin
            phase_in   = PH_HEADER;
            hidx_in    = 2'd0;
            type_in    = 8'd0;
            length_in  = 8'd0;
            handle_in  = 16'd0;
            left_in    = 8'd0;
            strings_in = 8'd0;
            in_str_in  = 1'b0;
            stopped_in = 1'b0;
         end
      end else begin
         case (phase_ff)
            PH_HEADER: begin
               case (hidx_ff)
                  2'd0: begin
                     type_in = b;
                     hidx_in = 2'd1;
                  end
                  2'd1: begin
                     length_in            = b;
                     result.struct_length = b;
                     result.string_count  = 8'd0;
                     if (b == NUL_BYTE) begin
                        res_vld       = 1'b1;
                        result.status = ST_TABLE_END;
                        stopped_in    = 1'b1;
                     end else if ({8'd0, b} >= table_size) begin
                        res_vld       = 1'b1;
                        result.status = ST_TOO_LONG;
                        stopped_in    = 1'b1;
                     end else if (b < HEADER_BYTES) begin
                        res_vld       = 1'b1;
                        result.status = ST_TOO_SHORT;
                        stopped_in    = 1'b1;
                     end else begin
                        hidx_in = 2'd2;
                     end
                  end
                  2'd2: begin
                     handle_in = {8'd0, b};
                     hidx_in   = 2'd3;
                  end
                  default: begin
                     handle_in = {b, handle_ff[7:0]};
                     hidx_in   = 2'd0;
                     if (length_ff > HEADER_BYTES) begin
                        left_in  = length_ff - HEADER_BYTES;
                        phase_in = PH_SKIP;
                     end else begin
                        phase_in = PH_FIRST;
                     end
                  end
               endcase
            end
            PH_SKIP: begin
               left_in = left_ff - 8'd1;
               if (left_ff == 8'd1) begin
                  phase_in = PH_FIRST;
               end
            end
            PH_FIRST: begin
               if (b == NUL_BYTE) begin
                  phase_in = PH_LEADNULL;
               end else begin
                  in_str_in = 1'b1;
                  phase_in  = PH_STRINGS;
               end
            end
            PH_LEADNULL: begin
               res_vld             = 1'b1;
               result.string_count = 8'd0;
               phase_in   = PH_HEADER;
               hidx_in    = 2'd0;
               type_in    = 8'd0;
               length_in  = 8'd0;
               handle_in  = 16'd0;
               left_in    = 8'd0;
               strings_in = 8'd0;
               in_str_in  = 1'b0;
               if (b != NUL_BYTE && !last) begin
                  type_in = b;
                  hidx_in = 2'd1;
               end
            end
            default: begin
               if (b != NUL_BYTE) begin
                  in_str_in = 1'b1;
               end else if (in_str_ff) begin
                  if (strings_ff != 8'hFF) begin
                     strings_in = strings_ff + 8'd1;
                  end
                  in_str_in = 1'b0;
               end else begin
                  res_vld    = 1'b1;
                  phase_in   = PH_HEADER;
                  hidx_in    = 2'd0;
                  type_in    = 8'd0;
                  length_in  = 8'd0;
                  handle_in  = 16'd0;
                  left_in    = 8'd0;
                  strings_in = 8'd0;
                  in_str_in  = 1'b0;
               end
            end
         endcase

         if (last) begin
            busy = (phase_in != PH_HEADER) || (hidx_in != 2'd0);
            if (!res_vld && busy) begin
               res_vld              = 1'b1;
               result.struct_type   = type_in;
               result.struct_handle = handle_in;
               result.struct_length = length_in;
               result.string_count  = strings_in;
               result.status        = ST_TRUNCATED;
            end
            phase_in   = PH_HEADER;
            hidx_in    = 2'd0;
            type_in    = 8'd0;
            length_in  = 8'd0;
            handle_in  = 16'd0;
            left_in    = 8'd0;
            strings_in = 8'd0;
            in_str_in  = 1'b0;
            stopped_in = 1'b0;
         end
      end
   end

   assign adv       = item_valid && (!res_vld || out_free);
   assign flow.take = adv;
   assign flow.load = adv && res_vld;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HEADER;
         hidx_ff    <= 2'd0;
         type_ff    <= 8'd0;
         length_ff  <= 8'd0;
         handle_ff  <= 16'd0;
         left_ff    <= 8'd0;
         strings_ff <= 8'd0;
         in_str_ff  <= 1'b0;
         stopped_ff <= 1'b0;
      end else if (adv) begin
         phase_ff   <= phase_in;
         hidx_ff    <= hidx_in;
         type_ff    <= type_in;
         length_ff  <= length_in;
         handle_ff  <= handle_in;
         left_ff    <= left_in;
         strings_ff <= strings_in;
         in_str_ff  <= in_str_in;
         stopped_ff <= stopped_in;
      end
   end

endmodule

// ===== rtl/core/swt_out_stage.sv =====
// Result register feeding the response channel.
// Depends on swt_pkg and swt_rsp_if.
module swt_out_stage (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  swt_pkg::swt_result_type result,
   output logic                    out_free,
   swt_rsp_if.source               rsp_if
);
   import swt_pkg::*;

   logic           vld_ff, vld_in;
   swt_result_type res_ff;

   assign out_free = !vld_ff || rsp_if.ready;
   assign vld_in   = load || (vld_ff && !rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= result;
      end
   end

   assign rsp_if.valid         = vld_ff;
   assign rsp_if.struct_type   = res_ff.struct_type;
   assign rsp_if.struct_handle = res_ff.struct_handle;
   assign rsp_if.struct_length = res_ff.struct_length;
   assign rsp_if.string_count  = res_ff.string_count;
   assign rsp_if.status        = res_ff.status;

endmodule

// ===== tb/swt_checker.sv =====
// Checker for the structure table walker: watches the byte, result and register channels.
// Predicts each structure result from the accepted bytes and compares it in order.
// Depends on swt_pkg and the channel interfaces in swt_ifs.
module swt_checker (
   input  logic clock,
   input  logic reset,
   swt_req_if   req_mon,
   swt_rsp_if   rsp_mon,
   swt_csr_if   csr_mon,
   output int   fail_count,
   output int   pending,
   output int   results_seen
);
   timeunit 1ns;
   timeprecision 1ps;
   import swt_pkg::*;

   swt_phase_type  ph;
   logic [1:0]     hdr_idx;
   logic [7:0]     cur_type;
   logic [7:0]     cur_len;
   logic [15:0]    cur_handle;
   logic [7:0]     skip_left;
   logic [7:0]     str_cnt;
   logic           in_str;
   logic           halted;
   logic [15:0]    tbl_size;

   swt_result_type struct_q[$];
   int             n_fail = 0;
   int             n_results = 0;

   initial begin
      fail_count   = 0;
      pending      = 0;
      results_seen = 0;
   end

   task automatic next_struct();
      ph         = PH_HEADER;
      hdr_idx    = 2'd0;
      cur_type   = 8'h00;
      cur_len    = 8'h00;
      cur_handle = 16'h0000;
      skip_left  = 8'h00;
      str_cnt    = 8'h00;
      in_str     = 1'b0;
   endtask

   task automatic clear_walk();
      next_struct();
      halted = 1'b0;
   endtask

   function automatic swt_result_type make_result(swt_status_type st, logic [7:0] cnt);
      swt_result_type r;
      r.struct_type   = cur_type;
      r.struct_handle = cur_handle;
      r.struct_length = cur_len;
      r.string_count  = cnt;
      r.status        = st;
      return r;
   endfunction

   task automatic take_header(input logic [7:0] b, output bit stop, output swt_result_type r);
      stop = 1'b0;
      r    = '0;
      case (hdr_idx)
         2'd0: begin
            cur_type = b;
            hdr_idx  = 2'd1;
         end
         2'd1: begin
            cur_len = b;
            if (b == NUL_BYTE) begin
               r    = make_result(ST_TABLE_END, 8'h00);
               stop = 1'b1;
            end else if ({8'h00, b} >= tbl_size) begin
               r    = make_result(ST_TOO_LONG, 8'h00);
               stop = 1'b1;
            end else if (b < HEADER_BYTES) begin
               r    = make_result(ST_TOO_SHORT, 8'h00);
               stop = 1'b1;
            end else begin
               hdr_idx = 2'd2;
            end
            if (stop) halted = 1'b1;
         end
         2'd2: begin
            cur_handle = {8'h00, b};
            hdr_idx    = 2'd3;
         end
         default: begin
            cur_handle[15:8] = b;
            hdr_idx          = 2'd0;
            if (cur_len > HEADER_BYTES) begin
               skip_left = cur_len - HEADER_BYTES;
               ph        = PH_SKIP;
            end else begin
               ph = PH_FIRST;
            end
         end
      endcase
   endtask

   task automatic walk_byte(input logic [7:0] b, input logic last);
      bit             got;
      bit             stop;
      swt_result_type r;
      swt_result_type spare;
      got = 1'b0;
      r   = '0;
      if (halted) begin
         if (last) clear_walk();
         return;
      end
      case (ph)
         PH_HEADER: take_header(b, got, r);
         PH_SKIP: begin
            skip_left = skip_left - 8'd1;
            if (skip_left == 8'd0) ph = PH_FIRST;
         end
         PH_FIRST: begin
            if (b == NUL_BYTE) begin
               ph = PH_LEADNULL;
            end else begin
               in_str = 1'b1;
               ph     = PH_STRINGS;
            end
         end
         PH_LEADNULL: begin
            r   = make_result(ST_COMPLETE, 8'h00);
            got = 1'b1;
            next_struct();
            // non-null byte that is not the last opens the next structure
            if (b != NUL_BYTE && !last) take_header(b, stop, spare);
         end
         default: begin
            if (b != NUL_BYTE) begin
               in_str = 1'b1;
            end else if (in_str) begin
               if (str_cnt != 8'hFF) str_cnt = str_cnt + 8'd1;
               in_str = 1'b0;
            end else begin
               r   = make_result(ST_COMPLETE, str_cnt);
               got = 1'b1;
               next_struct();
            end
         end
      endcase
      if (last) begin
         if (!got && (ph != PH_HEADER || hdr_idx != 2'd0)) begin
            r   = make_result(ST_TRUNCATED, str_cnt);
            got = 1'b1;
         end
         clear_walk();
      end
      if (got) struct_q.push_back(r);
   endtask

   always @(posedge clock) begin
      swt_result_type want;
      swt_result_type seen;
      bit             bad;
      if (reset) begin
         clear_walk();
         tbl_size = TABLE_SIZE_INIT;
         struct_q.delete();
      end else begin
         if (csr_mon.valid && csr_mon.ready) tbl_size = csr_mon.data;
         if (req_mon.valid && req_mon.ready) walk_byte(req_mon.data_byte, req_mon.last_byte);
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen.struct_type   = rsp_mon.struct_type;
            seen.struct_handle = rsp_mon.struct_handle;
            seen.struct_length = rsp_mon.struct_length;
            seen.string_count  = rsp_mon.string_count;
            seen.status        = swt_status_type'(rsp_mon.status);
            n_results++;
            if (struct_q.size() == 0) begin
               n_fail++;
               if (n_fail <= 10)
                  $display("unexpected: type %02h handle %04h len %02h strings %02h status %0d",
                           seen.struct_type, seen.struct_handle, seen.struct_length,
                           seen.string_count, seen.status);
            end else begin
               want = struct_q.pop_front();
               bad  = (seen.struct_type   !== want.struct_type)   ||
                      (seen.struct_handle !== want.struct_handle) ||
                      (seen.struct_length !== want.struct_length) ||
                      (seen.string_count  !== want.string_count)  ||
                      (seen.status        !== want.status);
               if (bad) begin
                  n_fail++;
                  if (n_fail <= 10) begin
                     $display("expected type %02h handle %04h len %02h strings %02h status %0d",
                              want.struct_type, want.struct_handle, want.struct_length,
                              want.string_count, want.status);
                     $display("got      type %02h handle %04h len %02h strings %02h status %0d",
                              seen.struct_type, seen.struct_handle, seen.struct_length,
                              seen.string_count, seen.status);
                  end
               end
            end
         end
      end
      fail_count   <= n_fail;
      pending      <= struct_q.size();
      results_seen <= n_results;
   end

endmodule

// ===== tb/tb.sv =====
// Top of the structure table walker testbench: clock, reset, byte and register stimulus.
// Drives directed and random tables through the walker and gives the verdict.
// Depends on swt_pkg, swt_ifs, smbios_table_walker and swt_checker.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import swt_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int N_PHASES    = 8;

   logic clock;
   logic reset;
   logic steady;
   int   hold_reqs;
   int   cycle_count = 0;
   int   sent_items  = 0;
   int   n_writes    = 0;
   int   fail_count;
   int   pending;
   int   results_seen;

   logic [7:0] tbl_q[$];

   swt_req_if req_ch ();
   swt_rsp_if rsp_ch ();
   swt_csr_if csr_ch ();

   smbios_table_walker u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   swt_checker u_check (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_ch),
      .rsp_mon      (rsp_ch),
      .csr_mon      (csr_ch),
      .fail_count   (fail_count),
      .pending      (pending),
      .results_seen (results_seen)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles", cycle_count);
      $display("status: fail");
      $finish;
   end

   initial begin
      int hold_left;
      int hold_seen;
      hold_left = 0;
      hold_seen = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_reqs != hold_seen) begin
            hold_seen = hold_reqs;
            hold_left = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (steady) begin
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= 24);
         end
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic last);
      if (!steady) begin
         while ($urandom_range(99) < 24) begin
            req_ch.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_ch.valid     <= 1'b1;
      req_ch.data_byte <= b;
      req_ch.last_byte <= last;
      do @(posedge clock); while (!req_ch.ready);
      sent_items++;
   endtask

   task automatic send_tbl();
      foreach (tbl_q[i]) send_byte(tbl_q[i], i == tbl_q.size() - 1);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_table_size(input logic [15:0] v);
      csr_ch.valid <= 1'b1;
      csr_ch.data  <= v;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      n_writes++;
   endtask

   task automatic push_rand();
      tbl_q.push_back(8'($urandom_range(255)));
   endtask

   task automatic add_struct();
      int pick;
      int flen;
      int n_str;
      pick = $urandom_range(99);
      if (pick < 80) flen = $urandom_range(4, 10);
      else if (pick < 92) flen = $urandom_range(11, 40);
      else if (pick < 95) flen = $urandom_range(41, 255);
      else flen = $urandom_range(1, 3);
      push_rand();
      tbl_q.push_back(8'(flen));
      repeat (2) push_rand();
      repeat (flen > 4 ? flen - 4 : 0) push_rand();
      n_str = ($urandom_range(9) < 3) ? 0 : $urandom_range(1, 3);
      if (n_str == 0) begin
         tbl_q.push_back(NUL_BYTE);
         if ($urandom_range(1)) tbl_q.push_back(NUL_BYTE);
      end else begin
         repeat (n_str) begin
            repeat ($urandom_range(1, 4)) tbl_q.push_back(8'($urandom_range(1, 255)));
            tbl_q.push_back(NUL_BYTE);
         end
         tbl_q.push_back(NUL_BYTE);
      end
   endtask

   task automatic build_random_tbl();
      int pick;
      int cut;
      tbl_q.delete();
      pick = $urandom_range(99);
      if (pick < 10) begin
         repeat ($urandom_range(1, 20)) begin
            if ($urandom_range(9) < 3) tbl_q.push_back(NUL_BYTE);
            else push_rand();
         end
      end else begin
         repeat ($urandom_range(1, 4)) add_struct();
         if (pick < 55) begin
            push_rand();
            tbl_q.push_back(NUL_BYTE);
            repeat ($urandom_range(0, 2)) push_rand();
         end else if (pick < 75) begin
            cut = $urandom_range(1, tbl_q.size());
            while (tbl_q.size() > cut) void'(tbl_q.pop_back());
         end
      end
   endtask

   initial begin
      logic [8:0]  directed_q[$];
      logic [15:0] size_list[N_PHASES];
      int          budget_list[N_PHASES];
      int          phase_end;
      directed_q  = '{9'h000, 9'h004, 9'h0FF, 9'h0FF, 9'h000, 9'h000,
                      9'h0FF, 9'h005, 9'h000, 9'h000, 9'h0AA, 9'h041, 9'h000, 9'h000,
                      9'h07F, 9'h004, 9'h034, 9'h012, 9'h000, 9'h180,
                      9'h001, 9'h100,
                      9'h002, 9'h102,
                      9'h003, 9'h006, 9'h101};
      size_list   = '{16'hFFFF, 16'd1, 16'd4, 16'd5, 16'd255, 16'd256, 16'd0, 16'hFFFF};
      budget_list = '{550, 25, 30, 60, 120, 100, 100, 150};
      size_list[6] = 16'($urandom_range(6, 65534));
      req_ch.valid     <= 1'b0;
      req_ch.data_byte <= 8'h00;
      req_ch.last_byte <= 1'b0;
      csr_ch.valid     <= 1'b0;
      csr_ch.data      <= 16'h0000;
      steady           <= 1'b0;
      hold_reqs        <= 0;
      reset            <= 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_q[i]) send_byte(directed_q[i][7:0], directed_q[i][8]);
      drain();

      for (int p = 0; p < N_PHASES; p++) begin
         write_table_size(size_list[p]);
         if (p == N_PHASES - 1) steady <= 1'b1;
         phase_end = sent_items + budget_list[p];
         if (p == 0) begin
            // one structure with more strings than the counter holds
            tbl_q.delete();
            push_rand();
            tbl_q.push_back(HEADER_BYTES);
            repeat (2) push_rand();
            repeat (257) begin
               tbl_q.push_back(8'($urandom_range(1, 255)));
               tbl_q.push_back(NUL_BYTE);
            end
            tbl_q.push_back(NUL_BYTE);
            send_tbl();
            hold_reqs <= hold_reqs + 1;
         end
         while (sent_items < phase_end) begin
            build_random_tbl();
            send_tbl();
         end
         drain();
         steady <= 1'b0;
      end

      repeat (20) @(posedge clock);
      $display("covered %0d table bytes over %0d table size settings", sent_items, n_writes);
      $display("checked %0d structure results, %0d failures, %0d results missing",
               results_seen, fail_count, pending);
      if (fail_count == 0 && pending == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/swt_pkg.sv
rtl/core/swt_ifs.sv
rtl/core/swt_in_stage.sv
rtl/core/swt_core.sv
rtl/core/swt_out_stage.sv
rtl/core/smbios_table_walker.sv
tb/swt_checker.sv
tb/tb.sv
